### rtl/cdacc_pkg.sv
// Shared constants, types and saturating arithmetic for the count deviation accumulator.
// No dependencies; cdacc_cell and the core import this package, cdacc_ram does not.
package cdacc_pkg;

    localparam int ORG_IDS  = 4096;
    localparam int SLOTS    = 256;
    localparam int SUM_BITS = 32;

    // Fixed field widths of the item interface
    localparam int REQ_W   = 3;
    localparam int ORG_FW  = 12;
    localparam int SLOT_FW = 8;
    localparam int CNT_W   = 16;
    localparam int OUT_W   = 32;

    localparam int ORG_AW  = (ORG_IDS > 1) ? $clog2(ORG_IDS) : 1;
    localparam int CELL_IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CMP_W   = (CELL_IW > SLOT_FW) ? CELL_IW : SLOT_FW;
    localparam int MAP_W   = SLOT_FW + 1;

    typedef enum logic [REQ_W-1:0] {
        REQ_MAP   = 3'd0,
        REQ_ACC   = 3'd1,
        REQ_BCAST = 3'd2,
        REQ_READ  = 3'd3,
        REQ_CLEAR = 3'd4
    } req_t;

    typedef logic [SUM_BITS-1:0] sum_t;

    // Command travelling down the row of cells; a read collects its sums on the way
    typedef struct packed {
        logic               valid;
        req_t               op;
        logic [SLOT_FW-1:0] slot;
        logic               add_exc;
        logic [CNT_W-1:0]   delta;
        logic [CNT_W-1:0]   ref_cnt;
        logic [CNT_W-1:0]   qry_cnt;
        logic [OUT_W-1:0]   total;
        logic [OUT_W-1:0]   missing;
        logic [OUT_W-1:0]   exceed;
    } cmd_t;

    function automatic sum_t sat_add(input sum_t a, input logic [CNT_W-1:0] b);
        logic [SUM_BITS:0] s;
        s = {1'b0, a} + (SUM_BITS+1)'(b);
        if (s[SUM_BITS])
            return '1;
        return s[SUM_BITS-1:0];
    endfunction

    // Clip a sum to the 32-bit result field
    function automatic logic [OUT_W-1:0] out_clip(input sum_t v);
        if (SUM_BITS > OUT_W && (v >> OUT_W) != '0)
            return '1;
        return OUT_W'(v);
    endfunction

endpackage

### rtl/cdacc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cdacc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/cdacc_cell.sv
// One accumulator cell: holds the three sums of one slot and passes commands on.
// Depends on cdacc_pkg.
module cdacc_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           adv,
    input  logic [cdacc_pkg::CELL_IW-1:0]  idx,
    input  cdacc_pkg::cmd_t                cmd_in,
    output cdacc_pkg::cmd_t                cmd_out
);

    import cdacc_pkg::*;

    sum_t total_reg, total_next;
    sum_t missing_reg, missing_next;
    sum_t exceed_reg, exceed_next;
    cmd_t cmd_reg, cmd_next;
    logic hit;

    assign hit = (CMP_W'(cmd_in.slot) == CMP_W'(idx));

    always_comb
    begin
        total_next   = total_reg;
        missing_next = missing_reg;
        exceed_next  = exceed_reg;
        cmd_next     = cmd_in;
        if (cmd_in.valid)
        begin
            unique case (cmd_in.op)
                REQ_ACC:
                begin
                    if (hit)
                    begin
                        if (cmd_in.add_exc)
                            exceed_next = sat_add(exceed_reg, cmd_in.delta);
                        else
                            missing_next = sat_add(missing_reg, cmd_in.delta);
                        total_next = sat_add(total_reg, cmd_in.ref_cnt);
                    end
                end
                REQ_BCAST:
                begin
                    exceed_next = sat_add(exceed_reg, cmd_in.qry_cnt);
                end
                REQ_READ:
                begin
                    if (hit)
                    begin
                        cmd_next.total   = out_clip(total_reg);
                        cmd_next.missing = out_clip(missing_reg);
                        cmd_next.exceed  = out_clip(exceed_reg);
                    end
                end
                REQ_CLEAR:
                begin
                    total_next   = '0;
                    missing_next = '0;
                    exceed_next  = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg     <= '0;
            total_reg   <= '0;
            missing_reg <= '0;
            exceed_reg  <= '0;
        end
        else if (adv)
        begin
            cmd_reg     <= cmd_next;
            total_reg   <= total_next;
            missing_reg <= missing_next;
            exceed_reg  <= exceed_next;
        end
    end

    assign cmd_out = cmd_reg;

endmodule

### rtl/count_deviation_accumulator_core.sv
// Count deviation accumulator top: organism map RAM (cdacc_ram), a front stage and a row of
// SLOTS cdacc_cell instances; constants and types from cdacc_pkg.
// Throughput one item per cycle unless a sweep runs or a result waits at a stalled output.
// A read passes the front stage, the row of cells every command walks through and the output
// register. Reset (rst_n, asynchronous, active low) zeroes every sum, then sweeps all ORG_IDS
// (4096) map entries unmapped; a clear item starts the same sweep and no item is accepted meanwhile.
module count_deviation_accumulator_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // org_id[11:0], slot[19:12], ref_count[35:20],
                                   // query_count[51:36], zero fill [55:52]
    input  logic [2:0]  s_tuser,   // req_type[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata    // total_sum[31:0], missing_sum[63:32],
                                   // exceeding_sum[95:64]
);

    import cdacc_pkg::*;

    typedef enum logic [1:0] {
        ST_SWEEP = 2'b01,
        ST_RUN   = 2'b10
    } state_t;

    // Item fields
    logic [REQ_W-1:0]   req_type;
    logic [ORG_FW-1:0]  org_id;
    logic [SLOT_FW-1:0] slot;
    logic [CNT_W-1:0]   ref_count;
    logic [CNT_W-1:0]   query_count;

    assign req_type    = s_tuser;
    assign org_id      = s_tdata[11:0];
    assign slot        = s_tdata[19:12];
    assign ref_count   = s_tdata[35:20];
    assign query_count = s_tdata[51:36];

    state_t             state_reg, state_next;
    logic [ORG_AW-1:0]  sweep_cnt_reg, sweep_cnt_next;
    logic               stg_valid_reg, stg_valid_next;
    logic [REQ_W-1:0]   stg_req_reg;
    logic               stg_org_ok_reg;
    logic               stg_add_exc_reg;
    logic [CNT_W-1:0]   stg_delta_reg;
    logic [CNT_W-1:0]   stg_ref_reg;
    logic [CNT_W-1:0]   stg_qry_reg;
    logic [SLOT_FW-1:0] stg_slot_reg;
    logic               out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]   out_total_reg, out_missing_reg, out_exceed_reg;

    logic               accept;
    logic               adv;
    logic               org_ok;
    logic               sweep_done;
    logic               map_we;
    logic [ORG_AW-1:0]  map_waddr;
    logic [MAP_W-1:0]   map_wdata;
    logic [MAP_W-1:0]   map_rdata;
    logic               inj_valid;
    cmd_t               chain [SLOTS+1];

    // The whole row moves together; hold it while a result waits at the output
    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_RUN) && (!stg_valid_reg || adv);
    assign accept   = s_tvalid && s_tready;
    assign org_ok   = int'(org_id) < ORG_IDS;
    assign sweep_done = (sweep_cnt_reg == ORG_AW'(ORG_IDS - 1));

    // Map RAM: the sweep writes unmapped entries, a map item binds an id at acceptance.
    // The lookup for an accumulate is read at acceptance and used in the front stage.
    always_comb
    begin
        map_we    = 1'b0;
        map_waddr = ORG_AW'(org_id);
        map_wdata = {1'b1, slot};
        if (state_reg == ST_SWEEP)
        begin
            map_we    = 1'b1;
            map_waddr = sweep_cnt_reg;
            map_wdata = '0;
        end
        else if (accept && req_type == REQ_MAP && org_ok && int'(slot) < SLOTS)
        begin
            map_we = 1'b1;
        end
    end

    cdacc_ram #(
        .WIDTH (MAP_W),
        .DEPTH (ORG_IDS)
    ) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .re    (accept),
        .raddr (ORG_AW'(org_id)),
        .rdata (map_rdata)
    );

    // Sweep sequencer and front stage control
    always_comb
    begin
        state_next     = state_reg;
        sweep_cnt_next = sweep_cnt_reg;
        unique case (state_reg)
            ST_SWEEP:
            begin
                sweep_cnt_next = sweep_cnt_reg + 1'b1;
                if (sweep_done)
                begin
                    state_next     = ST_RUN;
                    sweep_cnt_next = '0;
                end
            end
            ST_RUN:
            begin
                if (accept && req_type == REQ_CLEAR)
                begin
                    state_next     = ST_SWEEP;
                    sweep_cnt_next = '0;
                end
            end
            default:
            begin
                state_next     = ST_SWEEP;
                sweep_cnt_next = '0;
            end
        endcase

        if (accept)
            stg_valid_next = 1'b1;
        else if (adv)
            stg_valid_next = 1'b0;
        else
            stg_valid_next = stg_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            sweep_cnt_reg <= '0;
            stg_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_cnt_reg <= sweep_cnt_next;
            stg_valid_reg <= stg_valid_next;
        end
    end

    // Front stage payload: work out the deviation and which sum it feeds
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stg_req_reg     <= req_type;
            stg_org_ok_reg  <= org_ok;
            stg_slot_reg    <= slot;
            stg_ref_reg     <= ref_count;
            stg_qry_reg     <= query_count;
            stg_add_exc_reg <= (query_count > ref_count);
            stg_delta_reg   <= (query_count > ref_count) ? (query_count - ref_count)
                                                         : (ref_count - query_count);
        end
    end

    // Issue into the row; drop maps, unknown codes and accumulates of unmapped ids
    always_comb
    begin
        inj_valid = 1'b0;
        if (stg_valid_reg)
        begin
            case (stg_req_reg) inside
                REQ_ACC:
                    inj_valid = stg_org_ok_reg && map_rdata[MAP_W-1];
                REQ_BCAST, REQ_READ, REQ_CLEAR:
                    inj_valid = 1'b1;
                default:
                    inj_valid = 1'b0;
            endcase
        end

        chain[0]         = '0;
        chain[0].valid   = inj_valid;
        chain[0].op      = req_t'(stg_req_reg);
        chain[0].slot    = (stg_req_reg == REQ_ACC) ? map_rdata[SLOT_FW-1:0] : stg_slot_reg;
        chain[0].add_exc = stg_add_exc_reg;
        chain[0].delta   = stg_delta_reg;
        chain[0].ref_cnt = stg_ref_reg;
        chain[0].qry_cnt = stg_qry_reg;
    end

    // Row of cells, one per slot
    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        cdacc_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .idx     (CELL_IW'(i)),
            .cmd_in  (chain[i]),
            .cmd_out (chain[i+1])
        );
    end

    // Output register: take a read off the end of the row
    always_comb
    begin
        if (adv)
            out_valid_next = chain[SLOTS].valid && chain[SLOTS].op == REQ_READ;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_total_reg   <= chain[SLOTS].total;
            out_missing_reg <= chain[SLOTS].missing;
            out_exceed_reg  <= chain[SLOTS].exceed;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_exceed_reg, out_missing_reg, out_total_reg};

endmodule
